// ----- rtl/sonar_pkg.sv -----
// shared types, constants and the forward ramp table for the sonar drive controller
// no dependencies; used by every module in rtl/
`default_nettype none

package sonar_pkg;

    localparam int DIST_W  = 13;
    localparam int SPEED_W = 8;
    localparam int COUNT_W = 8;
    localparam int TICKS_W = 8;

    // forward ramp length in ticks, 1 .. 255
    localparam int RAMP_TICKS     = 50;
    localparam int RAMP_IDX_W     = $clog2(RAMP_TICKS + 1);
    localparam int RAMP_LUT_DEPTH = 2 ** RAMP_IDX_W;

    localparam logic [COUNT_W-1:0] BACKUP_LOW  = 8'd10;
    localparam logic [COUNT_W-1:0] BACKUP_HIGH = 8'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [SPEED_W-1:0] HALF_SPEED  = 8'd127;
    localparam logic [SPEED_W-1:0] ROT_SPEED   = 8'd50;
    localparam logic [SPEED_W-1:0] FULL_SPEED  = 8'd255;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        CFG_STOP_DIST  = 2'd0,
        CFG_SLOW_DIST  = 2'd1,
        CFG_ROT_TICKS  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MOVE_STOP    = 2'd0,
        MOVE_FORWARD = 2'd1,
        MOVE_BACK    = 2'd2,
        MOVE_ROTATE  = 2'd3
    } move_code_t;

    typedef struct packed {
        logic [DIST_W-1:0]  stop_distance;
        logic [DIST_W-1:0]  slow_distance;
        logic [TICKS_W-1:0] rotate_ticks;
    } cfg_t;

    // packed from msb down, so move_code sits in the lowest bits
    typedef struct packed {
        logic               buzzer_start;
        logic [SPEED_W-1:0] right_speed;
        logic               right_forward;
        logic [SPEED_W-1:0] left_speed;
        logic               left_forward;
        move_code_t         move_code;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } result_pair_t;

    typedef logic [SPEED_W-1:0] ramp_lut_t [RAMP_LUT_DEPTH];

    function automatic ramp_lut_t build_ramp_lut();
        ramp_lut_t lut;
        int pct;
        for (int i = 0; i < RAMP_LUT_DEPTH; i++)
        begin
            if (i < RAMP_TICKS)
            begin
                pct    = (i * 100) / RAMP_TICKS;
                lut[i] = SPEED_W'((pct * 255) / 100);
            end
            else
            begin
                lut[i] = FULL_SPEED;
            end
        end
        return lut;
    endfunction

    localparam ramp_lut_t RAMP_LUT = build_ramp_lut();

endpackage

`default_nettype wire

// ----- rtl/sonar_decide.sv -----
// per-tick decision logic and the three tick counters
// depends on sonar_pkg
`default_nettype none

module sonar_decide (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sonar_pkg::cfg_t               cfg,
    input  wire logic [sonar_pkg::DIST_W-1:0]  front_left_dist,
    input  wire logic [sonar_pkg::DIST_W-1:0]  front_right_dist,
    input  wire logic [sonar_pkg::DIST_W-1:0]  side_left_dist,
    input  wire logic                          advance,
    output sonar_pkg::result_pair_t            pair
);

    logic [sonar_pkg::COUNT_W-1:0] ramp_reg, ramp_next;
    logic [sonar_pkg::COUNT_W-1:0] rotate_reg, rotate_next;
    logic [sonar_pkg::COUNT_W-1:0] backup_reg, backup_next;

    logic [sonar_pkg::COUNT_W-1:0] ramp_inc;
    logic slow_band, blocked, left_clear;
    logic backing, rotating;

    function automatic logic [sonar_pkg::COUNT_W-1:0] sat_inc(
        input logic [sonar_pkg::COUNT_W-1:0] v);
        return (v == sonar_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic sonar_pkg::result_t make_result(
        input sonar_pkg::move_code_t code, input logic lf,
        input logic [sonar_pkg::SPEED_W-1:0] ls, input logic rf,
        input logic [sonar_pkg::SPEED_W-1:0] rs, input logic buz);
        sonar_pkg::result_t r;
        r.move_code     = code;
        r.left_forward  = lf;
        r.left_speed    = ls;
        r.right_forward = rf;
        r.right_speed   = rs;
        r.buzzer_start  = buz;
        return r;
    endfunction

    always_comb
    begin
        slow_band  = (front_left_dist < cfg.slow_distance && front_left_dist > cfg.stop_distance)
                  || (front_right_dist < cfg.slow_distance
                      && front_right_dist > cfg.stop_distance);
        blocked    = (front_left_dist < cfg.stop_distance && front_left_dist != '0)
                  || (front_right_dist < cfg.stop_distance && front_right_dist != '0);
        left_clear = (side_left_dist > cfg.stop_distance) || (side_left_dist == '0);
        ramp_inc   = sat_inc(ramp_reg);
        backing    = (backup_reg > sonar_pkg::BACKUP_LOW) && (backup_reg < sonar_pkg::BACKUP_HIGH);
        rotating   = (blocked && left_clear)
                  || (rotate_reg != '0 && rotate_reg < cfg.rotate_ticks && left_clear);
    end

    always_comb
    begin
        ramp_next   = ramp_inc;
        rotate_next = rotate_reg;
        backup_next = backup_reg;
        pair.two    = 1'b0;
        pair.second = make_result(sonar_pkg::MOVE_STOP, 1'b0, '0, 1'b0, '0, 1'b0);
        pair.first  = pair.second;
        priority if (backing)
        begin
            pair.first  = make_result(sonar_pkg::MOVE_BACK, 1'b0, sonar_pkg::HALF_SPEED,
                                      1'b0, sonar_pkg::HALF_SPEED, 1'b0);
            backup_next = backup_reg + 1'b1;
            ramp_next   = '0;
        end
        else if (slow_band && rotate_reg == '0)
        begin
            pair.first = make_result(sonar_pkg::MOVE_FORWARD, 1'b1, sonar_pkg::HALF_SPEED,
                                     1'b1, sonar_pkg::HALF_SPEED, 1'b0);
        end
        else if (rotating)
        begin
            // entering a rotation: stop first, then rotate
            pair.second = make_result(sonar_pkg::MOVE_ROTATE, 1'b0, sonar_pkg::ROT_SPEED,
                                      1'b1, sonar_pkg::ROT_SPEED, 1'b0);
            pair.two    = (rotate_reg == '0);
            if (rotate_reg != '0)
            begin
                pair.first = pair.second;
            end
            rotate_next = sat_inc(rotate_reg);
            ramp_next   = '0;
        end
        else if (blocked)
        begin
            // boxed in, left side not clear either
            rotate_next = '0;
            backup_next = sat_inc(backup_reg);
            pair.first  = make_result(sonar_pkg::MOVE_STOP, 1'b0, '0, 1'b0, '0, 1'b1);
        end
        else if (ramp_inc < sonar_pkg::COUNT_W'(sonar_pkg::RAMP_TICKS))
        begin
            rotate_next = '0;
            backup_next = '0;
            pair.first  = make_result(sonar_pkg::MOVE_FORWARD, 1'b1,
                                      sonar_pkg::RAMP_LUT[ramp_inc[sonar_pkg::RAMP_IDX_W-1:0]],
                                      1'b1,
                                      sonar_pkg::RAMP_LUT[ramp_inc[sonar_pkg::RAMP_IDX_W-1:0]],
                                      1'b0);
        end
        else
        begin
            rotate_next = '0;
            pair.first  = make_result(sonar_pkg::MOVE_FORWARD, 1'b1, sonar_pkg::FULL_SPEED,
                                      1'b1, sonar_pkg::FULL_SPEED, 1'b0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg   <= '0;
            rotate_reg <= '0;
            backup_reg <= '0;
        end
        else if (advance)
        begin
            ramp_reg   <= ramp_next;
            rotate_reg <= rotate_next;
            backup_reg <= backup_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sonar_out_stage.sv -----
// result register holding the one or two results of a tick, drained in order
// depends on sonar_pkg
`default_nettype none

module sonar_out_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire sonar_pkg::result_pair_t pair,
    output logic                         free,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output sonar_pkg::result_t           out_result,
    output logic                         out_last
);

    sonar_pkg::result_pair_t pair_reg;
    logic valid_reg, valid_next;
    logic phase_reg, phase_next;
    logic take;

    always_comb
    begin
        out_valid  = valid_reg;
        out_result = phase_reg ? pair_reg.second : pair_reg.first;
        out_last   = phase_reg || !pair_reg.two;
        take       = valid_reg && out_ready;
        free       = !valid_reg || (take && out_last);
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (take)
        begin
            valid_next = !out_last;
            phase_next = !out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= pair;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sonar_obstacle_avoid_drive_top.sv -----
// top level of the sonar obstacle-avoiding drive controller
// depends on sonar_pkg, sonar_decide, sonar_out_stage
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_tvalid / s_tready       s_tdata: three sonar distances
//  m_axis    out  m_tvalid / m_tready       m_tdata: wheel command, m_tlast: last of tick
//  cfg       in   cfg_wr_en                 cfg_index, cfg_wdata
//
// a tick passes an input register, then the decision logic, into the result
// register. an item that gives one result uses the output port once, a rotation
// entry (stop, then rotate) uses it twice, so the rate is one item per cycle
// while m_tready is high, apart from rotation entries. the input register
// refills while a result waits; with m_tready low the result register holds,
// and s_tready drops once the input register holds a tick too. reset clears all
// counters and loads the register defaults; no clearing pass.
`default_nettype none

module sonar_obstacle_avoid_drive_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // fields from bit 0: front_left_dist[12:0], front_right_dist[25:13],
    // side_left_dist[38:26], zero pad [39]
    input  wire logic [sonar_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // fields from bit 0: move_code[1:0], left_forward[2], left_speed[10:3],
    // right_forward[11], right_speed[19:12], buzzer_start[20], zero pad [23:21]
    output logic [sonar_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wr_en,
    input  wire sonar_pkg::cfg_index_t             cfg_index,
    input  wire logic [sonar_pkg::DIST_W-1:0]      cfg_wdata
);

    localparam int PAD_W = sonar_pkg::OUT_TDATA_W - $bits(sonar_pkg::result_t);

    // configuration registers
    sonar_pkg::cfg_t cfg_reg, cfg_next;

    // input register
    logic                         in_valid_reg;
    logic [sonar_pkg::DIST_W-1:0] fl_reg, fr_reg, sl_reg;

    logic                    stage_free;
    logic                    advance;
    sonar_pkg::result_pair_t pair;
    sonar_pkg::result_t      out_result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sonar_pkg::CFG_STOP_DIST: cfg_next.stop_distance = cfg_wdata;
                sonar_pkg::CFG_SLOW_DIST: cfg_next.slow_distance = cfg_wdata;
                sonar_pkg::CFG_ROT_TICKS:
                    cfg_next.rotate_ticks = cfg_wdata[sonar_pkg::TICKS_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_distance <= 13'd1000;
            cfg_reg.slow_distance <= 13'd2000;
            cfg_reg.rotate_ticks  <= 8'd25;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // the input register moves on whenever the result register can take the tick
    assign advance  = in_valid_reg && stage_free;
    assign s_tready = !in_valid_reg || stage_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            fl_reg <= s_tdata[12:0];
            fr_reg <= s_tdata[25:13];
            sl_reg <= s_tdata[38:26];
        end
    end

    sonar_decide u_decide (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .front_left_dist  (fl_reg),
        .front_right_dist (fr_reg),
        .side_left_dist   (sl_reg),
        .advance          (advance),
        .pair             (pair)
    );

    sonar_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .pair       (pair),
        .free       (stage_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_result};

    // the first of two results of a tick is always the stop before a rotation
    a_first_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[1:0] == sonar_pkg::MOVE_STOP))
        else $error("non-final result of a tick is not a stop");

    // after that stop is taken the rotate result follows at once
    a_rotate_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[1:0] == sonar_pkg::MOVE_ROTATE && m_tlast))
        else $error("rotate result missing after entry stop");

    // the buzzer only goes with a stop
    a_buzzer_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[1:0] == sonar_pkg::MOVE_STOP))
        else $error("buzzer set on a moving command");

    // a held tick in the input register is never dropped
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input tick lost while waiting");

endmodule

`default_nettype wire
